[hdl/rfp_pkg.sv]
package rfp_pkg;

    localparam int MAX_PAYLOAD_DEF = 64;

    localparam logic [7:0] START_BYTE     = 8'h55;
    localparam logic [7:0] CMD_SINGLE     = 8'h01;
    localparam logic [7:0] CMD_CONTINUOUS = 8'h02;
    localparam int         RANGING_LEN    = 10;

    localparam int RESULT_W = 40;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_CMD,
        PH_LEN,
        PH_DATA,
        PH_CHECK
    } t_phase;

    // Packed so that frame_cmd lands in the lowest bits of tdata.
    typedef struct packed {
        logic [23:0] distance_dm;
        logic        is_ranging;
        logic [6:0]  frame_len;
        logic [7:0]  frame_cmd;
    } t_result;

endpackage

[hdl/rangefinder_frame_parser_core.sv]
// Rangefinder frame parser: takes one received serial byte per beat and
// recovers frames of start byte 0x55, command, length, payload and XOR
// checksum. Every good frame yields one output beat with command, length,
// a ranging flag and the distance in 0.1 m (payload bytes 1..3, big-endian,
// only for command 1 or 2 with length 10, else zero). Bad frames and stray
// bytes yield nothing. A byte is taken every cycle while s_axis_tready is
// high; a frame's result is buffered with its checksum byte. Results sit in
// a two-entry output buffer, so s_axis_tready falls only while two results
// wait on the output side. Lengths above MAX_PAYLOAD abort the frame.
module rangefinder_frame_parser_core #(
    parameter int MAX_PAYLOAD = rfp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,  // rx_byte
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // frame_cmd[7:0], frame_len[14:8], is_ranging[15], distance_dm[39:16]
    output logic [rfp_pkg::RESULT_W-1:0] m_axis_tdata
);
    import rfp_pkg::*;

    logic    beat;
    logic    res_valid;
    logic    room;
    t_result res;
    t_result out_res;

    assign beat          = s_axis_tvalid && room;
    assign s_axis_tready = room;
    assign m_axis_tdata  = out_res;

    rfp_parser #(
        .MaxPayload (MAX_PAYLOAD)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (beat),
        .i_byte      (s_axis_tdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    rfp_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_data      (res),
        .o_room      (room),
        .o_valid     (m_axis_tvalid),
        .i_pop_ready (m_axis_tready),
        .o_data      (out_res)
    );

endmodule

[hdl/rfp_parser.sv]
module rfp_parser #(
    parameter int MaxPayload = rfp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_beat,
    input  logic [7:0]      i_byte,
    output logic            o_res_valid,
    output rfp_pkg::t_result o_res
);
    import rfp_pkg::*;

    localparam int LenW = $clog2(MaxPayload + 1);

    t_phase            r_phase;
    t_phase            n_phase;
    logic [7:0]        r_cmd;
    logic [LenW-1:0]   r_len;
    logic [LenW-1:0]   r_idx;
    logic [LenW-1:0]   n_idx;
    logic [7:0]        r_xor;
    logic [23:0]       r_dist;
    logic              len_over;
    logic              ranging;

    assign n_idx    = r_idx + LenW'(1);
    assign len_over = i_byte > 8'(MaxPayload);

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_HUNT: begin
                if (i_byte == START_BYTE) begin
                    n_phase = PH_CMD;
                end
            end
            PH_CMD: n_phase = PH_LEN;
            PH_LEN: begin
                if (len_over) begin
                    n_phase = PH_HUNT;
                end else if (i_byte == 8'd0) begin
                    n_phase = PH_CHECK;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (n_idx >= r_len) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: n_phase = PH_HUNT;
            default:  n_phase = PH_HUNT;
        endcase
    end

    always_comb begin
        ranging = ((r_cmd == CMD_SINGLE) || (r_cmd == CMD_CONTINUOUS))
                  && (r_len == LenW'(RANGING_LEN));
        o_res_valid       = i_beat && (r_phase == PH_CHECK) && (r_xor == i_byte);
        o_res.frame_cmd   = r_cmd;
        o_res.frame_len   = 7'(r_len);
        o_res.is_ranging  = ranging;
        o_res.distance_dm = ranging ? r_dist : 24'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_cmd   <= '0;
            r_len   <= '0;
            r_idx   <= '0;
            r_xor   <= '0;
            r_dist  <= '0;
        end else if (i_beat) begin
            r_phase <= n_phase;
            case (r_phase)
                PH_HUNT: begin
                    if (i_byte == START_BYTE) begin
                        r_xor  <= i_byte;
                        r_dist <= '0;
                    end
                end
                PH_CMD: begin
                    r_cmd <= i_byte;
                    r_xor <= r_xor ^ i_byte;
                end
                PH_LEN: begin
                    r_len <= i_byte[LenW-1:0];
                    r_xor <= r_xor ^ i_byte;
                    r_idx <= '0;
                end
                PH_DATA: begin
                    if (r_idx == LenW'(1)) begin
                        r_dist[23:16] <= i_byte;
                    end
                    if (r_idx == LenW'(2)) begin
                        r_dist[15:8] <= i_byte;
                    end
                    if (r_idx == LenW'(3)) begin
                        r_dist[7:0] <= i_byte;
                    end
                    r_xor <= r_xor ^ i_byte;
                    r_idx <= n_idx;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

[hdl/rfp_out_buf.sv]
module rfp_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rfp_pkg::t_result i_data,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_pop_ready,
    output rfp_pkg::t_result o_data
);
    import rfp_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop     = r_main_valid && i_pop_ready;
    assign o_room  = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= i_push;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
                r_skid <= i_data;
            end else begin
                r_main <= i_data;
            end
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid <= i_data;
            end else begin
                r_main <= i_data;
            end
        end
    end

endmodule

[hdl/rfp_checker.sv]
module rfp_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [rfp_pkg::RESULT_W-1:0] m_axis_tdata
);
    import rfp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    a_ranging_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[15] |->
            (m_axis_tdata[14:8] == 7'(RANGING_LEN))
            && ((m_axis_tdata[7:0] == CMD_SINGLE) || (m_axis_tdata[7:0] == CMD_CONTINUOUS)))
        else $error("ranging flag on a non-ranging frame");

    a_dist_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[15] |-> m_axis_tdata[39:16] == 24'd0)
        else $error("distance reported on a non-ranging frame");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result waiting");

endmodule

bind rangefinder_frame_parser_core rfp_checker u_rfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
